/* src/eac_pkg.sv */
package eac_pkg;

   // Time base and field widths
   localparam int TIME_WIDTH    = 32;
   localparam int VOL_WIDTH     = 5;
   localparam int DUTY_WIDTH    = 8;
   localparam int SPAN_WIDTH    = 22;
   localparam int PULSE_WIDTH   = 16;
   localparam int MINUTE_WIDTH  = 8;
   localparam int CSR_IDX_WIDTH = 3;
   localparam int CSR_WIDTH     = 22;

   // Shared shift-add multiplier: 22-bit multiplicand, 8-bit multiplier
   localparam int MUL_A_WIDTH = 22;
   localparam int MUL_B_WIDTH = 8;
   localparam int MUL_P_WIDTH = MUL_A_WIDTH + MUL_B_WIDTH;
   localparam int MUL_CNT_WIDTH = $clog2(MUL_B_WIDTH);

   // Ramp divider: numerator below 31 * ramp_time, quotient below 32
   localparam int DIV_N_WIDTH = SPAN_WIDTH + VOL_WIDTH;
   localparam int DIV_Q_WIDTH = VOL_WIDTH;
   localparam int DIV_CNT_WIDTH = $clog2(DIV_Q_WIDTH);

   // Constants
   localparam logic [MUL_A_WIDTH-1:0] MS_PER_MINUTE = MUL_A_WIDTH'(60000);
   localparam logic [DUTY_WIDTH-1:0]  DUTY_OFF      = 8'd0;
   localparam logic [DUTY_WIDTH-1:0]  DUTY_PULSE    = 8'd128;
   localparam logic [DUTY_WIDTH-1:0]  DUTY_FULL     = 8'd255;

   // Commands
   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_START  = 2'd1;
   localparam logic [1:0] CMD_STOP   = 2'd2;
   localparam logic [1:0] CMD_SNOOZE = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] REG_VOLUME_MIN      = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_VOLUME_MAX      = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_RAMP_TIME       = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_ESCALATION_TIME = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_PULSE_ON_TIME   = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_PULSE_OFF_TIME  = 3'd5;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_PLAYER_READY    = 3'd6;

   // Register reset values
   localparam logic [VOL_WIDTH-1:0]   RST_VOLUME_MIN = 5'd5;
   localparam logic [VOL_WIDTH-1:0]   RST_VOLUME_MAX = 5'd30;
   localparam logic [SPAN_WIDTH-1:0]  RST_RAMP_TIME  = 22'd60000;
   localparam logic [SPAN_WIDTH-1:0]  RST_ESC_TIME   = 22'd60000;
   localparam logic [PULSE_WIDTH-1:0] RST_PULSE_ON   = 16'd500;
   localparam logic [PULSE_WIDTH-1:0] RST_PULSE_OFF  = 16'd500;

   typedef struct packed {
      logic [1:0]              command;
      logic [MINUTE_WIDTH-1:0] snooze_minutes;
   } req_type;

   typedef struct packed {
      logic [VOL_WIDTH-1:0]  volume;
      logic [DUTY_WIDTH-1:0] vibration_duty;
      logic                  is_alarming;
      logic                  is_snoozed;
      logic                  send_volume;
      logic                  start_playback;
      logic                  pause_playback;
   } rsp_type;

endpackage

/* src/eac_mul.sv */
module eac_mul
   import eac_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [MUL_A_WIDTH-1:0] mcand,
   input  logic [MUL_B_WIDTH-1:0] mplier,
   output logic                   done,
   output logic [MUL_P_WIDTH-1:0] product
);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [MUL_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [MUL_P_WIDTH-1:0]   acc_ff, acc_in;
   logic [MUL_P_WIDTH-1:0]   mcand_ff, mcand_in;
   logic [MUL_B_WIDTH-1:0]   mplier_ff, mplier_in;

   // One multiplier bit per cycle, LSB first
   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = '0;
         acc_in    = '0;
         mcand_in  = MUL_P_WIDTH'(mcand);
         mplier_in = mplier;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = {mcand_ff[MUL_P_WIDTH-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[MUL_B_WIDTH-1:1]};
         cnt_in    = cnt_ff + 1'b1;
         if (cnt_ff == MUL_CNT_WIDTH'(MUL_B_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff    <= cnt_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

/* src/eac_div.sv */
module eac_div
   import eac_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [DIV_N_WIDTH-1:0] numer,
   input  logic [SPAN_WIDTH-1:0]  denom,
   output logic                   done,
   output logic [DIV_Q_WIDTH-1:0] quotient
);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DIV_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [DIV_N_WIDTH-1:0]   rem_ff, rem_in;
   logic [DIV_N_WIDTH-1:0]   dsh_ff, dsh_in;
   logic [DIV_Q_WIDTH-1:0]   q_ff, q_in;

   // Restoring division, one quotient bit per cycle, MSB first
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = numer;
         dsh_in  = DIV_N_WIDTH'(denom) << (DIV_Q_WIDTH - 1);
         q_in    = '0;
      end else if (busy_ff) begin
         if (rem_ff >= dsh_ff) begin
            rem_in = rem_ff - dsh_ff;
            q_in   = {q_ff[DIV_Q_WIDTH-2:0], 1'b1};
         end else begin
            q_in   = {q_ff[DIV_Q_WIDTH-2:0], 1'b0};
         end
         dsh_in = {1'b0, dsh_ff[DIV_N_WIDTH-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_WIDTH'(DIV_Q_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

/* src/escalating_alarm_controller.sv */
// Start and stop pass S_EXEC and S_DONE; a snooze while alarming adds S_SNZ on the multiplier,
// a tick adds S_EVAL, and S_RAMP and S_DIV when the volume ramp runs the shift-add multiplier and
// the restoring divider. One command is in work at a time: a new beat is taken only once
// the last result is registered; a waiting result holds back only the command behind it.
// Reset (synchronous, active high) restores all configuration registers to their defaults,
// clears the time base and leaves the alarm idle.
module escalating_alarm_controller
   import eac_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_type                  rsp_data,
   input  logic                     csr_we,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [CSR_WIDTH-1:0]     csr_wdata
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_EVAL = 3'd2;
   localparam logic [2:0] S_RAMP = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_SNZ  = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   // Configuration registers
   logic [VOL_WIDTH-1:0]   vmin_ff, vmax_ff;
   logic [SPAN_WIDTH-1:0]  ramp_ff, esc_ff;
   logic [PULSE_WIDTH-1:0] on_ff, off_ff;
   logic                   ready_ff;

   // Controller state
   logic [2:0]              state_ff, state_in;
   logic [1:0]              cmd_ff, cmd_in;
   logic [MINUTE_WIDTH-1:0] min_ff, min_in;
   logic [TIME_WIDTH-1:0]   time_ff, time_in;
   logic [TIME_WIDTH-1:0]   start_ff, start_in;
   logic [TIME_WIDTH-1:0]   dead_ff, dead_in;
   logic [TIME_WIDTH-1:0]   toggle_ff, toggle_in;
   logic [VOL_WIDTH-1:0]    vol_ff, vol_in;
   logic [DUTY_WIDTH-1:0]   duty_ff, duty_in;
   logic                    vib_ff, vib_in;
   logic                    alarm_ff, alarm_in;
   logic                    snz_ff, snz_in;
   logic                    send_ff, send_in;
   logic                    play_ff, play_in;
   logic                    pause_ff, pause_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   // Datapath helpers
   logic [TIME_WIDTH-1:0]  snz_diff, elapsed, since;
   logic                   begin_alarm;
   logic                   vol_upd;
   logic [VOL_WIDTH-1:0]   vol_new;
   logic [VOL_WIDTH:0]     ramp_sum;
   logic                   mul_start, mul_done, div_done;
   logic [MUL_A_WIDTH-1:0] mul_a;
   logic [MUL_B_WIDTH-1:0] mul_b;
   logic [MUL_P_WIDTH-1:0] mul_p;
   logic [DIV_Q_WIDTH-1:0] div_q;
   logic                   div_start;

   assign snz_diff = time_ff - dead_ff;
   assign elapsed  = time_ff - start_ff;
   assign since    = time_ff - toggle_ff;
   assign ramp_sum = {1'b0, vmin_ff} + {1'b0, div_q};

   // Multiplier operands: snooze minutes times ms per minute, or volume span times elapsed time
   assign mul_a = (state_ff == S_EXEC) ? MS_PER_MINUTE : elapsed[MUL_A_WIDTH-1:0];
   assign mul_b = (state_ff == S_EXEC) ? min_ff :
                  MUL_B_WIDTH'(vmax_ff - vmin_ff);

   assign div_start = (state_ff == S_RAMP) && mul_done;

   eac_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_a),
      .mplier  (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   eac_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (mul_p[DIV_N_WIDTH-1:0]),
      .denom    (ramp_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // Command sequencer
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      min_in       = min_ff;
      time_in      = time_ff;
      start_in     = start_ff;
      dead_in      = dead_ff;
      toggle_in    = toggle_ff;
      vol_in       = vol_ff;
      duty_in      = duty_ff;
      vib_in       = vib_ff;
      alarm_in     = alarm_ff;
      snz_in       = snz_ff;
      send_in      = send_ff;
      play_in      = play_ff;
      pause_in     = pause_ff;
      begin_alarm  = 1'b0;
      vol_upd      = 1'b0;
      vol_new      = vmax_ff;
      mul_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_data.command;
               min_in   = req_data.snooze_minutes;
               send_in  = 1'b0;
               play_in  = 1'b0;
               pause_in = 1'b0;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_DONE;
            case (cmd_ff)
               CMD_TICK: begin
                  time_in  = time_ff + 1'b1;
                  state_in = S_EVAL;
               end
               CMD_START: begin
                  begin_alarm = !alarm_ff;
               end
               CMD_STOP: begin
                  alarm_in = 1'b0;
                  snz_in   = 1'b0;
                  pause_in = ready_ff;
                  duty_in  = DUTY_OFF;
               end
               default: begin
                  if (alarm_ff) begin
                     mul_start = 1'b1;
                     state_in  = S_SNZ;
                  end
               end
            endcase
         end
         S_SNZ: begin
            if (mul_done) begin
               dead_in  = time_ff + TIME_WIDTH'(mul_p);
               alarm_in = 1'b0;
               snz_in   = 1'b1;
               pause_in = ready_ff;
               duty_in  = DUTY_OFF;
               state_in = S_DONE;
            end
         end
         S_EVAL: begin
            state_in = S_DONE;
            if (snz_ff) begin
               // Deadline passed when the wrapped difference is non-negative
               if (!snz_diff[TIME_WIDTH-1]) begin
                  snz_in      = 1'b0;
                  begin_alarm = 1'b1;
               end
            end else if (alarm_ff) begin
               if (elapsed < TIME_WIDTH'(esc_ff)) begin
                  // Vibration pulse train
                  if (vib_ff) begin
                     if (since >= TIME_WIDTH'(on_ff)) begin
                        vib_in    = 1'b0;
                        duty_in   = DUTY_OFF;
                        toggle_in = time_ff;
                     end
                  end else if (since >= TIME_WIDTH'(off_ff)) begin
                     vib_in    = 1'b1;
                     duty_in   = DUTY_PULSE;
                     toggle_in = time_ff;
                  end
                  // Volume ramp: trivial cases end here, else multiply and divide
                  if (vmax_ff <= vmin_ff || elapsed >= TIME_WIDTH'(ramp_ff)) begin
                     vol_upd = 1'b1;
                  end else begin
                     mul_start = 1'b1;
                     state_in  = S_RAMP;
                  end
               end else begin
                  vol_upd = 1'b1;
                  duty_in = DUTY_FULL;
               end
            end
         end
         S_RAMP: begin
            if (mul_done) begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               vol_upd  = 1'b1;
               vol_new  = (ramp_sum > {1'b0, vmax_ff}) ? vmax_ff :
                          ramp_sum[VOL_WIDTH-1:0];
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.volume          = vol_ff;
               rsp_data_in.vibration_duty  = duty_ff;
               rsp_data_in.is_alarming     = alarm_ff;
               rsp_data_in.is_snoozed      = snz_ff;
               rsp_data_in.send_volume     = send_ff;
               rsp_data_in.start_playback  = play_ff;
               rsp_data_in.pause_playback  = pause_ff;
               state_in                    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Volume change pulses the player only on a real change
      if (vol_upd && vol_new != vol_ff) begin
         vol_in  = vol_new;
         send_in = send_ff | ready_ff;
      end

      // Fresh alarm start
      if (begin_alarm) begin
         alarm_in  = 1'b1;
         snz_in    = 1'b0;
         start_in  = time_ff;
         vol_in    = vmin_ff;
         send_in   = ready_ff;
         play_in   = ready_ff;
         vib_in    = 1'b1;
         toggle_in = time_ff;
         duty_in   = DUTY_PULSE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         time_ff      <= '0;
         start_ff     <= '0;
         dead_ff      <= '0;
         toggle_ff    <= '0;
         vol_ff       <= RST_VOLUME_MIN;
         duty_ff      <= DUTY_OFF;
         vib_ff       <= 1'b0;
         alarm_ff     <= 1'b0;
         snz_ff       <= 1'b0;
         send_ff      <= 1'b0;
         play_ff      <= 1'b0;
         pause_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         time_ff      <= time_in;
         start_ff     <= start_in;
         dead_ff      <= dead_in;
         toggle_ff    <= toggle_in;
         vol_ff       <= vol_in;
         duty_ff      <= duty_in;
         vib_ff       <= vib_in;
         alarm_ff     <= alarm_in;
         snz_ff       <= snz_in;
         send_ff      <= send_in;
         play_ff      <= play_in;
         pause_ff     <= pause_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      min_ff      <= min_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         vmin_ff  <= RST_VOLUME_MIN;
         vmax_ff  <= RST_VOLUME_MAX;
         ramp_ff  <= RST_RAMP_TIME;
         esc_ff   <= RST_ESC_TIME;
         on_ff    <= RST_PULSE_ON;
         off_ff   <= RST_PULSE_OFF;
         ready_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            REG_VOLUME_MIN:      vmin_ff  <= csr_wdata[VOL_WIDTH-1:0];
            REG_VOLUME_MAX:      vmax_ff  <= csr_wdata[VOL_WIDTH-1:0];
            REG_RAMP_TIME:       ramp_ff  <= csr_wdata[SPAN_WIDTH-1:0];
            REG_ESCALATION_TIME: esc_ff   <= csr_wdata[SPAN_WIDTH-1:0];
            REG_PULSE_ON_TIME:   on_ff    <= csr_wdata[PULSE_WIDTH-1:0];
            REG_PULSE_OFF_TIME:  off_ff   <= csr_wdata[PULSE_WIDTH-1:0];
            REG_PLAYER_READY:    ready_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
   import eac_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 24;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 225;

   // Index with no register behind it; writes to it must change nothing
   localparam logic [CSR_IDX_WIDTH-1:0] REG_NONE = 3'd7;

   typedef struct packed {
      logic [VOL_WIDTH-1:0]   vmin;
      logic [VOL_WIDTH-1:0]   vmax;
      logic [SPAN_WIDTH-1:0]  ramp;
      logic [SPAN_WIDTH-1:0]  esc;
      logic [PULSE_WIDTH-1:0] on_ms;
      logic [PULSE_WIDTH-1:0] off_ms;
      logic                   ready;
   } alarm_cfg_type;

   typedef struct packed {
      logic [1:0]              cmd;
      logic [MINUTE_WIDTH-1:0] mins;
      logic                    pinned;
      rsp_type                 value;
   } dir_row_type;

   typedef struct packed {
      logic    pinned;
      rsp_type value;
   } typed_out_type;

   // Opening sequence at reset settings; result typed in where obvious
   localparam dir_row_type DIRECTED [23] = '{
      '{CMD_TICK,   8'd0,   1'b1, '{5'd5, 8'd0,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{CMD_STOP,   8'd0,   1'b1, '{5'd5, 8'd0,   1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{CMD_SNOOZE, 8'd255, 1'b1, '{5'd5, 8'd0,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{CMD_START,  8'd0,   1'b1, '{5'd5, 8'd128, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0}},
      '{CMD_START,  8'd0,   1'b1, '{5'd5, 8'd128, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{CMD_TICK,   8'd0,   1'b1, '{5'd5, 8'd128, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{CMD_SNOOZE, 8'd0,   1'b1, '{5'd5, 8'd0,   1'b0, 1'b1, 1'b0, 1'b0, 1'b1}},
      '{CMD_TICK,   8'd0,   1'b1, '{5'd5, 8'd128, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0}},
      '{CMD_SNOOZE, 8'd255, 1'b1, '{5'd5, 8'd0,   1'b0, 1'b1, 1'b0, 1'b0, 1'b1}},
      '{CMD_TICK,   8'd0,   1'b1, '{5'd5, 8'd0,   1'b0, 1'b1, 1'b0, 1'b0, 1'b0}},
      '{CMD_START,  8'd0,   1'b1, '{5'd5, 8'd128, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0}},
      '{CMD_SNOOZE, 8'd170, 1'b1, '{5'd5, 8'd0,   1'b0, 1'b1, 1'b0, 1'b0, 1'b1}},
      '{CMD_STOP,   8'd0,   1'b1, '{5'd5, 8'd0,   1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{CMD_START,  8'd0,   1'b1, '{5'd5, 8'd128, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0}},
      '{CMD_SNOOZE, 8'd85,  1'b1, '{5'd5, 8'd0,   1'b0, 1'b1, 1'b0, 1'b0, 1'b1}},
      '{CMD_START,  8'd0,   1'b1, '{5'd5, 8'd128, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0}},
      '{CMD_TICK,   8'd0,   1'b0, '0},
      '{CMD_TICK,   8'd255, 1'b0, '0},
      '{CMD_TICK,   8'd0,   1'b0, '0},
      '{CMD_TICK,   8'd0,   1'b0, '0},
      '{CMD_TICK,   8'd0,   1'b0, '0},
      '{CMD_TICK,   8'd0,   1'b0, '0},
      '{CMD_STOP,   8'd0,   1'b1, '{5'd5, 8'd0,   1'b0, 1'b0, 1'b0, 1'b0, 1'b1}}
   };

   // Settings at the corners: escalation zero with ramp 1 and player off,
   // max below min with ramp zero, then two ordinary ramps
   localparam alarm_cfg_type FIXED_CFG [4] = '{
      '{5'd0,  5'd31, 22'd1,       22'd0,       16'd1,      16'd1,      1'b0},
      '{5'd31, 5'd0,  22'd0,       22'h3FFFFF,  16'hFFFF,   16'hFFFF,   1'b1},
      '{5'd2,  5'd29, 22'd40,      22'd150,     16'd3,      16'd5,      1'b1},
      '{5'd0,  5'd30, 22'h3FFFFF,  22'd100,     16'd7,      16'd2,      1'b1}
   };
   localparam int REQ_GAP [PHASES] = '{16, 0, 0, 16, 0, 16, 16, 16};
   localparam int RSP_GAP [PHASES] = '{16, 0, 0, 0, 16, 16, 16, 16};

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   logic    csr_we;
   logic [CSR_IDX_WIDTH-1:0] csr_index;
   logic [CSR_WIDTH-1:0]     csr_wdata;

   escalating_alarm_controller dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   int            cycle_count = 0;
   int            error_count = 0;
   int            max_req_gap = 16;
   int            max_rsp_gap = 16;
   bit            hold_rsp    = 1'b0;
   rsp_type       alarm_out_q [$];
   typed_out_type table_out_q [$];

   // Predictor copy of the registers
   logic [VOL_WIDTH-1:0]   cfg_vol_min;
   logic [VOL_WIDTH-1:0]   cfg_vol_max;
   logic [SPAN_WIDTH-1:0]  cfg_ramp_ms;
   logic [SPAN_WIDTH-1:0]  cfg_esc_ms;
   logic [PULSE_WIDTH-1:0] cfg_on_ms;
   logic [PULSE_WIDTH-1:0] cfg_off_ms;
   logic                   cfg_ready;

   // Predictor copy of the alarm state
   logic [TIME_WIDTH-1:0] now_ms;
   logic [TIME_WIDTH-1:0] alarm_t0;
   logic [TIME_WIDTH-1:0] snooze_until;
   logic [TIME_WIDTH-1:0] toggle_t;
   logic [VOL_WIDTH-1:0]  vol_level;
   logic [DUTY_WIDTH-1:0] duty_now;
   logic                  vib_on;
   logic                  alarming;
   logic                  snoozed;
   logic                  say_volume;
   logic                  say_play;
   logic                  say_pause;

   function automatic void start_alarm();
      if (!alarming) begin
         alarming   = 1'b1;
         snoozed    = 1'b0;
         alarm_t0   = now_ms;
         vol_level  = cfg_vol_min;
         say_volume = cfg_ready;
         say_play   = cfg_ready;
         vib_on     = 1'b1;
         toggle_t   = now_ms;
         duty_now   = DUTY_PULSE;
      end
   endfunction

   // Advances the predicted alarm by one command and returns its result
   function automatic rsp_type alarm_step(input req_type beat);
      rsp_type               res;
      logic [TIME_WIDTH-1:0] elapsed;
      logic [TIME_WIDTH-1:0] since;
      logic [TIME_WIDTH-1:0] lag;
      logic [VOL_WIDTH-1:0]  level;
      longint unsigned       rise;
      say_volume = 1'b0;
      say_play   = 1'b0;
      say_pause  = 1'b0;
      case (beat.command)
         CMD_TICK: begin
            now_ms = now_ms + 1'b1;
            if (snoozed) begin
               // deadline passed once the wrapped difference is non-negative
               lag = now_ms - snooze_until;
               if (!lag[TIME_WIDTH-1]) begin
                  snoozed = 1'b0;
                  start_alarm();
               end
            end else if (alarming) begin
               elapsed = now_ms - alarm_t0;
               if (elapsed < cfg_esc_ms) begin
                  // linear ramp, held at max when done or degenerate
                  if (cfg_vol_max <= cfg_vol_min || cfg_ramp_ms == '0 ||
                      elapsed >= cfg_ramp_ms) begin
                     level = cfg_vol_max;
                  end else begin
                     rise  = cfg_vol_max;
                     rise  = (rise - cfg_vol_min) * elapsed / cfg_ramp_ms;
                     level = cfg_vol_min + VOL_WIDTH'(rise);
                  end
                  if (level != vol_level) begin
                     vol_level  = level;
                     say_volume = cfg_ready;
                  end
                  since = now_ms - toggle_t;
                  if (vib_on) begin
                     if (since >= cfg_on_ms) begin
                        vib_on   = 1'b0;
                        duty_now = DUTY_OFF;
                        toggle_t = now_ms;
                     end
                  end else if (since >= cfg_off_ms) begin
                     vib_on   = 1'b1;
                     duty_now = DUTY_PULSE;
                     toggle_t = now_ms;
                  end
               end else begin
                  // escalated: full volume, continuous vibration
                  if (vol_level != cfg_vol_max) begin
                     vol_level  = cfg_vol_max;
                     say_volume = cfg_ready;
                  end
                  duty_now = DUTY_FULL;
               end
            end
         end
         CMD_START: start_alarm();
         CMD_STOP: begin
            alarming  = 1'b0;
            snoozed   = 1'b0;
            say_pause = cfg_ready;
            duty_now  = DUTY_OFF;
         end
         default: begin
            if (alarming) begin
               alarming     = 1'b0;
               snoozed      = 1'b1;
               snooze_until = now_ms + TIME_WIDTH'(beat.snooze_minutes) *
                              TIME_WIDTH'(MS_PER_MINUTE);
               say_pause    = cfg_ready;
               duty_now     = DUTY_OFF;
            end
         end
      endcase
      res.volume         = vol_level;
      res.vibration_duty = duty_now;
      res.is_alarming    = alarming;
      res.is_snoozed     = snoozed;
      res.send_volume    = say_volume;
      res.start_playback = say_play;
      res.pause_playback = say_pause;
      return res;
   endfunction

   // Watches every handshake: register writes, input beats, result beats
   always @(posedge clock) begin : beat_monitor
      rsp_type       want;
      rsp_type       got;
      typed_out_type row;
      if (reset) begin
         cfg_vol_min = RST_VOLUME_MIN;
         cfg_vol_max = RST_VOLUME_MAX;
         cfg_ramp_ms = RST_RAMP_TIME;
         cfg_esc_ms  = RST_ESC_TIME;
         cfg_on_ms   = RST_PULSE_ON;
         cfg_off_ms  = RST_PULSE_OFF;
         cfg_ready   = 1'b1;
         now_ms       = '0;
         alarm_t0     = '0;
         snooze_until = '0;
         toggle_t     = '0;
         vol_level    = RST_VOLUME_MIN;
         duty_now     = DUTY_OFF;
         vib_on       = 1'b0;
         alarming     = 1'b0;
         snoozed      = 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_VOLUME_MIN:      cfg_vol_min = csr_wdata[VOL_WIDTH-1:0];
               REG_VOLUME_MAX:      cfg_vol_max = csr_wdata[VOL_WIDTH-1:0];
               REG_RAMP_TIME:       cfg_ramp_ms = csr_wdata[SPAN_WIDTH-1:0];
               REG_ESCALATION_TIME: cfg_esc_ms  = csr_wdata[SPAN_WIDTH-1:0];
               REG_PULSE_ON_TIME:   cfg_on_ms   = csr_wdata[PULSE_WIDTH-1:0];
               REG_PULSE_OFF_TIME:  cfg_off_ms  = csr_wdata[PULSE_WIDTH-1:0];
               REG_PLAYER_READY:    cfg_ready   = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (alarm_out_q.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("cycle %0d: result beat with nothing expected", cycle_count);
            end else begin
               want = alarm_out_q.pop_front();
               if (got.volume !== want.volume ||
                   got.vibration_duty !== want.vibration_duty ||
                   got.is_alarming !== want.is_alarming ||
                   got.is_snoozed !== want.is_snoozed ||
                   got.send_volume !== want.send_volume ||
                   got.start_playback !== want.start_playback ||
                   got.pause_playback !== want.pause_playback) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $display("cycle %0d: expected vol %0d duty %0d alarm %b snz %b %s",
                              cycle_count, want.volume, want.vibration_duty,
                              want.is_alarming, want.is_snoozed,
                              $sformatf("send %b play %b pause %b", want.send_volume,
                                        want.start_playback, want.pause_playback));
                     $display("cycle %0d: got      vol %0d duty %0d alarm %b snz %b %s",
                              cycle_count, got.volume, got.vibration_duty,
                              got.is_alarming, got.is_snoozed,
                              $sformatf("send %b play %b pause %b", got.send_volume,
                                        got.start_playback, got.pause_playback));
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            row  = table_out_q.pop_front();
            want = alarm_step(req_data);
            alarm_out_q.push_back(row.pinned ? row.value : want);
         end
      end
   end

   // Result side: random stall after each beat, one long hold on request
   initial begin : rsp_sink
      int pause_cycles;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (rsp_valid && !rsp_stall) begin
            pause_cycles = $urandom_range(0, max_rsp_gap);
            if (pause_cycles > 0) begin
               rsp_stall <= 1'b1;
               repeat (pause_cycles) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("escalating_alarm_controller test failed");
         $finish;
      end
   end

   // Offer one command beat; returns right after the edge that took it
   task automatic send_cmd(input logic [1:0] cmd, input logic [MINUTE_WIDTH-1:0] mins,
                           input logic pinned, input rsp_type value);
      int            gap;
      typed_out_type row;
      gap = $urandom_range(0, max_req_gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      row.pinned = pinned;
      row.value  = value;
      table_out_q.push_back(row);
      req_valid <= 1'b1;
      req_data  <= '{command: cmd, snooze_minutes: mins};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Junk above the register width must be dropped
   task automatic write_reg(input logic [CSR_IDX_WIDTH-1:0] idx,
                            input logic [CSR_WIDTH-1:0] value, input int width);
      logic [CSR_WIDTH-1:0] mask;
      mask = (CSR_WIDTH'(1) << width) - 1'b1;
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= (CSR_WIDTH'($urandom) & ~mask) | (value & mask);
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (alarm_out_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      alarm_cfg_type cfg;
      int            sent;
      int            span;
      int            ticks;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      reset     = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i])
         send_cmd(DIRECTED[i].cmd, DIRECTED[i].mins, DIRECTED[i].pinned, DIRECTED[i].value);
      wait_drained();

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase < 4) begin
            cfg = FIXED_CFG[phase];
         end else begin
            cfg.vmin   = VOL_WIDTH'($urandom_range(0, 31));
            cfg.vmax   = VOL_WIDTH'($urandom_range(0, 31));
            cfg.ramp   = SPAN_WIDTH'($urandom_range(1, 250));
            cfg.esc    = SPAN_WIDTH'($urandom_range(0, 160));
            cfg.on_ms  = PULSE_WIDTH'($urandom_range(1, 25));
            cfg.off_ms = PULSE_WIDTH'($urandom_range(1, 25));
            cfg.ready  = ($urandom_range(0, 3) != 0);
         end
         write_reg(REG_VOLUME_MIN, CSR_WIDTH'(cfg.vmin), VOL_WIDTH);
         write_reg(REG_VOLUME_MAX, CSR_WIDTH'(cfg.vmax), VOL_WIDTH);
         write_reg(REG_RAMP_TIME, cfg.ramp, SPAN_WIDTH);
         write_reg(REG_ESCALATION_TIME, cfg.esc, SPAN_WIDTH);
         write_reg(REG_PULSE_ON_TIME, CSR_WIDTH'(cfg.on_ms), PULSE_WIDTH);
         write_reg(REG_PULSE_OFF_TIME, CSR_WIDTH'(cfg.off_ms), PULSE_WIDTH);
         write_reg(REG_PLAYER_READY, CSR_WIDTH'(cfg.ready), 1);
         write_reg(REG_NONE, CSR_WIDTH'($urandom), 0);
         csr_we <= 1'b0;

         max_req_gap = REQ_GAP[phase];
         max_rsp_gap = RSP_GAP[phase];
         // back up the result side so the block fills and stalls its input
         if (phase == 2)
            hold_rsp = 1'b1;

         // alarm sessions: start, a run of ticks with some noise, then an end
         span = (cfg.esc <= 160) ? int'(cfg.esc) + 40 : 100;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            send_cmd(CMD_START, MINUTE_WIDTH'($urandom), 1'b0, '0);
            ticks = $urandom_range(1, span);
            for (int t = 0; t < ticks; t++) begin
               if ($urandom_range(0, 99) < 4)
                  send_cmd(2'($urandom_range(0, 3)), MINUTE_WIDTH'($urandom), 1'b0, '0);
               else
                  send_cmd(CMD_TICK, MINUTE_WIDTH'($urandom), 1'b0, '0);
            end
            if ($urandom_range(0, 1) == 0)
               send_cmd(CMD_STOP, MINUTE_WIDTH'($urandom), 1'b0, '0);
            else if ($urandom_range(0, 2) == 0)
               send_cmd(CMD_SNOOZE, '0, 1'b0, '0);
            else
               send_cmd(CMD_SNOOZE, MINUTE_WIDTH'($urandom), 1'b0, '0);
            sent = sent + ticks + 2;
            ticks = $urandom_range(0, 4);
            for (int t = 0; t < ticks; t++)
               send_cmd(CMD_TICK, MINUTE_WIDTH'($urandom), 1'b0, '0);
            sent = sent + ticks;
         end
         wait_drained();
      end

      if (error_count == 0)
         $display("escalating_alarm_controller test passed");
      else
         $display("escalating_alarm_controller test failed");
      $finish;
   end

endmodule
